// ----- rtl/core/mrd_pkg.sv -----
// Package with the word types, function codes and length decode of the request deframer.
package mrd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 9;

  localparam logic [ByteW-1:0] FcReadCoils        = 8'd1;
  localparam logic [ByteW-1:0] FcReadDiscrete     = 8'd2;
  localparam logic [ByteW-1:0] FcReadHolding      = 8'd3;
  localparam logic [ByteW-1:0] FcReadInput        = 8'd4;
  localparam logic [ByteW-1:0] FcWriteCoil        = 8'd5;
  localparam logic [ByteW-1:0] FcWriteRegister    = 8'd6;
  localparam logic [ByteW-1:0] FcReadException    = 8'd7;
  localparam logic [ByteW-1:0] FcDiagnostics      = 8'd8;
  localparam logic [ByteW-1:0] FcEventCounter     = 8'd11;
  localparam logic [ByteW-1:0] FcEventLog         = 8'd12;
  localparam logic [ByteW-1:0] FcWriteCoils       = 8'd15;
  localparam logic [ByteW-1:0] FcWriteRegisters   = 8'd16;
  localparam logic [ByteW-1:0] FcReportServerId   = 8'd17;
  localparam logic [ByteW-1:0] FcReadFileRecord   = 8'd20;
  localparam logic [ByteW-1:0] FcWriteFileRecord  = 8'd21;
  localparam logic [ByteW-1:0] FcMaskWrite        = 8'd22;
  localparam logic [ByteW-1:0] FcReadWriteMulti   = 8'd23;
  localparam logic [ByteW-1:0] FcReadFifo         = 8'd24;

  localparam logic [IndexW-1:0] LenShort   = 9'd4;
  localparam logic [IndexW-1:0] LenFifo    = 9'd6;
  localparam logic [IndexW-1:0] LenStd     = 9'd8;
  localparam logic [IndexW-1:0] LenMask    = 9'd10;
  localparam logic [IndexW-1:0] BaseMulti  = 9'd9;
  localparam logic [IndexW-1:0] BaseFile   = 9'd5;
  localparam logic [IndexW-1:0] BaseRw     = 9'd13;

  localparam logic [IndexW-1:0] PosMultiCount = 9'd6;
  localparam logic [IndexW-1:0] PosFileCount  = 9'd2;
  localparam logic [IndexW-1:0] PosRwCount    = 9'd10;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [ByteW-1:0]  frame_byte;
    logic [IndexW-1:0] byte_index;
    logic              frame_first;
    logic              frame_last;
    logic              bad_function;
  } out_word_t;

  typedef struct packed {
    logic              supported;
    logic              fixed;
    logic [IndexW-1:0] length;
  } fc_info_t;

  function automatic fc_info_t fc_decode(input logic [ByteW-1:0] fc);
    fc_info_t info;
    info = '{supported: 1'b1, fixed: 1'b1, length: LenStd};
    case (fc)
      FcReadCoils, FcReadDiscrete, FcReadHolding, FcReadInput,
      FcWriteCoil, FcWriteRegister, FcDiagnostics: info.length = LenStd;
      FcReadException, FcEventCounter, FcEventLog,
      FcReportServerId: info.length = LenShort;
      FcMaskWrite: info.length = LenMask;
      FcReadFifo: info.length = LenFifo;
      FcWriteCoils, FcWriteRegisters, FcReadFileRecord,
      FcWriteFileRecord, FcReadWriteMulti: info.fixed = 1'b0;
      default: begin
        info.supported = 1'b0;
        info.fixed     = 1'b0;
      end
    endcase
    return info;
  endfunction

endpackage

// ----- rtl/core/mrd_stream_if.sv -----
// Valid/ready stream interface that carries one word of a given payload type.
interface mrd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/modbus_request_deframer_core.sv -----
// Modbus RTU request deframer: splits a request byte stream into frames by function code.
// The block takes one request byte per cycle unless the output stalls and returns it from
// an output register, tagged with its frame index and with first and last marks. The frame
// length comes from the function code in byte 1, either fixed or as a base plus the byte
// count found later in the frame; the CRC is not checked. An unsupported function code
// returns byte 1 with bad_function and frame_last set, and the next byte starts a new frame.
// Throughput is one word per cycle, set by the single output register, which takes a new
// word whenever it is empty or its word is taken in the same cycle.
module modbus_request_deframer_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  mrd_stream_if.sink   rx_i,
  mrd_stream_if.source frame_o
);

  logic [mrd_pkg::IndexW-1:0] pos_q, pos_d;
  logic [mrd_pkg::ByteW-1:0]  func_q, func_d;
  logic [mrd_pkg::IndexW-1:0] len_q, len_d;
  logic                       known_q, known_d;
  logic                       out_valid_q;
  mrd_pkg::out_word_t         out_q, out_d;

  logic                       accept;
  logic [mrd_pkg::ByteW-1:0]  b;
  mrd_pkg::fc_info_t          info;
  logic                       bad, last;
  logic [mrd_pkg::IndexW:0]   pos_inc;

  assign rx_i.ready    = !out_valid_q || frame_o.ready;
  assign accept        = rx_i.valid && rx_i.ready;
  assign b             = rx_i.data.rx_byte;
  assign info          = mrd_pkg::fc_decode(b);
  assign pos_inc       = {1'b0, pos_q} + {{mrd_pkg::IndexW{1'b0}}, 1'b1};
  assign frame_o.valid = out_valid_q;
  assign frame_o.data  = out_q;

  always_comb begin
    func_d  = func_q;
    len_d   = len_q;
    known_d = known_q;
    bad     = 1'b0;
    if (pos_q == '0) begin
      func_d  = '0;
      len_d   = '0;
      known_d = 1'b0;
    end else if (pos_q == mrd_pkg::IndexW'(1)) begin
      func_d = b;
      if (!info.supported) begin
        bad = 1'b1;
      end else if (info.fixed) begin
        len_d   = info.length;
        known_d = 1'b1;
      end
    end else if (!known_q) begin
      if ((func_q == mrd_pkg::FcWriteCoils || func_q == mrd_pkg::FcWriteRegisters)
          && pos_q == mrd_pkg::PosMultiCount) begin
        len_d   = mrd_pkg::BaseMulti + {1'b0, b};
        known_d = 1'b1;
      end else if ((func_q == mrd_pkg::FcReadFileRecord
                    || func_q == mrd_pkg::FcWriteFileRecord)
                   && pos_q == mrd_pkg::PosFileCount) begin
        len_d   = mrd_pkg::BaseFile + {1'b0, b};
        known_d = 1'b1;
      end else if (func_q == mrd_pkg::FcReadWriteMulti && pos_q == mrd_pkg::PosRwCount) begin
        len_d   = mrd_pkg::BaseRw + {1'b0, b};
        known_d = 1'b1;
      end
    end
    last = bad || (known_d && pos_inc >= {1'b0, len_d});

    out_d.frame_byte   = b;
    out_d.byte_index   = pos_q;
    out_d.frame_first  = (pos_q == '0);
    out_d.frame_last   = last;
    out_d.bad_function = bad;

    if (last) begin
      pos_d   = '0;
      func_d  = '0;
      len_d   = '0;
      known_d = 1'b0;
    end else begin
      pos_d = pos_inc[mrd_pkg::IndexW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      func_q      <= '0;
      len_q       <= '0;
      known_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q   <= pos_d;
        func_q  <= func_d;
        len_q   <= len_d;
        known_q <= known_d;
      end
      if (rx_i.ready) begin
        out_valid_q <= rx_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  a_first_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_first |-> out_q.byte_index == '0)
    else $error("frame_first on a word whose index is not zero");

  a_bad_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.bad_function |->
      out_q.frame_last && out_q.byte_index == mrd_pkg::IndexW'(1))
    else $error("bad_function without frame end at byte 1");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> pos_q == '0 && !known_q)
    else $error("frame did not restart after its last word");

  a_pos_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    known_q |-> pos_q < len_q)
    else $error("position reached the known frame length");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the Modbus request deframer core with random stimulus and stalls.
module tb;

  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned TailCycles = 8;

  logic clk_i;
  logic rst_ni;

  mrd_stream_if #(.payload_t(mrd_pkg::in_word_t))  rx_if ();
  mrd_stream_if #(.payload_t(mrd_pkg::out_word_t)) frame_if ();

  modbus_request_deframer_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_if),
    .frame_o (frame_if)
  );

  logic [mrd_pkg::ByteW-1:0] pending_bytes [$];
  mrd_pkg::out_word_t        expected_words [$];
  int unsigned               error_count;
  int unsigned               queued_count;
  int unsigned               send_idle_pct;
  int unsigned               recv_idle_pct;
  int unsigned               quiet_cycles;

  logic [mrd_pkg::IndexW-1:0] rx_position;
  logic [mrd_pkg::ByteW-1:0]  rx_function;
  logic [mrd_pkg::IndexW-1:0] rx_length;
  logic                       rx_length_known;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic report_error(input string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  // Returns the fixed frame length, 0 for a length set by a count byte, -1 if unsupported.
  function automatic int code_length(input logic [mrd_pkg::ByteW-1:0] code);
    case (code)
      mrd_pkg::FcReadCoils, mrd_pkg::FcReadDiscrete, mrd_pkg::FcReadHolding,
      mrd_pkg::FcReadInput, mrd_pkg::FcWriteCoil, mrd_pkg::FcWriteRegister,
      mrd_pkg::FcDiagnostics: return int'(mrd_pkg::LenStd);
      mrd_pkg::FcReadException, mrd_pkg::FcEventCounter, mrd_pkg::FcEventLog,
      mrd_pkg::FcReportServerId: return int'(mrd_pkg::LenShort);
      mrd_pkg::FcMaskWrite: return int'(mrd_pkg::LenMask);
      mrd_pkg::FcReadFifo: return int'(mrd_pkg::LenFifo);
      mrd_pkg::FcWriteCoils, mrd_pkg::FcWriteRegisters, mrd_pkg::FcReadFileRecord,
      mrd_pkg::FcWriteFileRecord, mrd_pkg::FcReadWriteMulti: return 0;
      default: return -1;
    endcase
  endfunction

  task automatic predict_frame_word(input logic [mrd_pkg::ByteW-1:0] b);
    mrd_pkg::out_word_t w;
    int                 fl;
    logic               is_last;
    w = '0;
    is_last = 1'b0;
    w.frame_byte  = b;
    w.byte_index  = rx_position;
    w.frame_first = (rx_position == '0);
    if (rx_position == '0) begin
      rx_length_known = 1'b0;
      rx_length       = '0;
      rx_function     = '0;
    end else if (rx_position == 9'd1) begin
      fl = code_length(b);
      rx_function = b;
      if (fl < 0) begin
        w.bad_function = 1'b1;
        is_last        = 1'b1;
      end else if (fl > 0) begin
        rx_length       = mrd_pkg::IndexW'(fl);
        rx_length_known = 1'b1;
      end
    end else if (!rx_length_known) begin
      if ((rx_function == mrd_pkg::FcWriteCoils ||
           rx_function == mrd_pkg::FcWriteRegisters) &&
          rx_position == mrd_pkg::PosMultiCount) begin
        rx_length       = mrd_pkg::BaseMulti + {1'b0, b};
        rx_length_known = 1'b1;
      end else if ((rx_function == mrd_pkg::FcReadFileRecord ||
                    rx_function == mrd_pkg::FcWriteFileRecord) &&
                   rx_position == mrd_pkg::PosFileCount) begin
        rx_length       = mrd_pkg::BaseFile + {1'b0, b};
        rx_length_known = 1'b1;
      end else if (rx_function == mrd_pkg::FcReadWriteMulti &&
                   rx_position == mrd_pkg::PosRwCount) begin
        rx_length       = mrd_pkg::BaseRw + {1'b0, b};
        rx_length_known = 1'b1;
      end
    end
    if (rx_length_known && ({1'b0, rx_position} + 10'd1) >= {1'b0, rx_length}) begin
      is_last = 1'b1;
    end
    w.frame_last = is_last;
    expected_words.push_back(w);
    if (is_last) begin
      rx_position     = '0;
      rx_length_known = 1'b0;
      rx_length       = '0;
      rx_function     = '0;
    end else begin
      rx_position = rx_position + 9'd1;
    end
  endtask

  // Queues one request; a nonzero cut below its length keeps only that many leading bytes.
  task automatic push_request(input logic [mrd_pkg::ByteW-1:0] addr,
                              input logic [mrd_pkg::ByteW-1:0] code,
                              input int count, input int cut);
    int fl;
    int total;
    int cpos;
    int i;
    fl   = code_length(code);
    cpos = -1;
    if (fl < 0) begin
      total = 2;
    end else if (fl > 0) begin
      total = fl;
    end else begin
      case (code)
        mrd_pkg::FcWriteCoils, mrd_pkg::FcWriteRegisters: begin
          cpos  = int'(mrd_pkg::PosMultiCount);
          total = int'(mrd_pkg::BaseMulti) + count;
        end
        mrd_pkg::FcReadFileRecord, mrd_pkg::FcWriteFileRecord: begin
          cpos  = int'(mrd_pkg::PosFileCount);
          total = int'(mrd_pkg::BaseFile) + count;
        end
        default: begin
          cpos  = int'(mrd_pkg::PosRwCount);
          total = int'(mrd_pkg::BaseRw) + count;
        end
      endcase
    end
    if (cut > 0 && cut < total) begin
      total = cut;
    end
    for (i = 0; i < total; i++) begin
      if (i == 0) begin
        pending_bytes.push_back(addr);
      end else if (i == 1) begin
        pending_bytes.push_back(code);
      end else if (i == cpos) begin
        pending_bytes.push_back(mrd_pkg::ByteW'(count));
      end else begin
        pending_bytes.push_back(mrd_pkg::ByteW'($urandom_range(255)));
      end
    end
    queued_count += total;
  endtask

  function automatic logic [mrd_pkg::ByteW-1:0] random_code(input bit supported);
    logic [mrd_pkg::ByteW-1:0] code;
    code = mrd_pkg::ByteW'($urandom_range(1, 24));
    while ((code_length(code) >= 0) != supported) begin
      code = supported ? mrd_pkg::ByteW'($urandom_range(1, 24))
                       : mrd_pkg::ByteW'($urandom_range(255));
    end
    return code;
  endfunction

  task automatic queue_random_traffic(input int unsigned n_bytes);
    int unsigned start;
    int unsigned r;
    int          count;
    int          i;
    start = queued_count;
    while (queued_count - start < n_bytes) begin
      r     = $urandom_range(99);
      count = ($urandom_range(39) == 0) ? $urandom_range(255) : $urandom_range(10);
      if (r < 8) begin
        push_request(mrd_pkg::ByteW'($urandom_range(255)), random_code(1'b0), 0, 0);
      end else if (r < 16) begin
        for (i = 0; i < int'($urandom_range(1, 3)); i++) begin
          pending_bytes.push_back(mrd_pkg::ByteW'($urandom_range(255)));
          queued_count++;
        end
      end else if (r < 26) begin
        push_request(mrd_pkg::ByteW'($urandom_range(255)), random_code(1'b1), count,
                     $urandom_range(1, 7));
      end else begin
        push_request(mrd_pkg::ByteW'($urandom_range(255)), random_code(1'b1), count, 0);
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_bytes.size() != 0 || rx_if.valid || expected_words.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic fire;
    if (!rst_ni) begin
      rx_if.valid     <= 1'b0;
      rx_if.data      <= '0;
      rx_position     = '0;
      rx_function     = '0;
      rx_length       = '0;
      rx_length_known = 1'b0;
    end else begin
      fire = rx_if.valid && rx_if.ready;
      if (fire) begin
        predict_frame_word(rx_if.data.rx_byte);
      end
      if (!rx_if.valid || fire) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_if.valid        <= 1'b1;
          rx_if.data.rx_byte <= pending_bytes.pop_front();
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_if.ready <= 1'b0;
    end else begin
      frame_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    mrd_pkg::out_word_t got;
    mrd_pkg::out_word_t want;
    if (rst_ni && frame_if.valid && frame_if.ready) begin
      got = frame_if.data;
      if (expected_words.size() == 0) begin
        report_error($sformatf("word %h arrived with nothing expected", got));
      end else begin
        want = expected_words.pop_front();
        if (got.frame_byte != want.frame_byte) begin
          report_error($sformatf("frame_byte %h, expected %h", got.frame_byte,
                                 want.frame_byte));
        end
        if (got.byte_index != want.byte_index) begin
          report_error($sformatf("byte_index %0d, expected %0d", got.byte_index,
                                 want.byte_index));
        end
        if (got.frame_first != want.frame_first) begin
          report_error($sformatf("frame_first %b, expected %b at index %0d",
                                 got.frame_first, want.frame_first, want.byte_index));
        end
        if (got.frame_last != want.frame_last) begin
          report_error($sformatf("frame_last %b, expected %b at index %0d",
                                 got.frame_last, want.frame_last, want.byte_index));
        end
        if (got.bad_function != want.bad_function) begin
          report_error($sformatf("bad_function %b, expected %b at index %0d",
                                 got.bad_function, want.bad_function, want.byte_index));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (frame_if.valid && frame_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    rx_if.valid    = 1'b0;
    rx_if.data     = '0;
    frame_if.ready = 1'b0;
    error_count    = 0;
    queued_count   = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 30;
    recv_idle_pct  = 76;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_request(8'h00, mrd_pkg::FcReadException, 0, 0);
    push_request(8'hFF, 8'h00, 0, 0);
    push_request(8'h7F, 8'hFF, 0, 0);
    push_request(8'h01, mrd_pkg::FcReadFileRecord, 0, 0);
    push_request(8'h80, mrd_pkg::FcReadFifo, 0, 0);
    push_request(8'h02, mrd_pkg::FcWriteRegisters, 0, 5);
    queue_random_traffic(600);
    wait_drained();

    send_idle_pct = 76;
    recv_idle_pct = 30;
    queue_random_traffic(300);
    wait_drained();
    queue_random_traffic(300);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_request(8'hFF, mrd_pkg::FcReadWriteMulti, 255, 0);
    push_request(8'h00, mrd_pkg::FcWriteCoils, 255, 0);
    queue_random_traffic(100);
    wait_drained();

    repeat (TailCycles) @(negedge clk_i);
    if (expected_words.size() != 0) begin
      report_error($sformatf("%0d expected words never arrived", expected_words.size()));
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
